// ===== rtl/ypcb_pkg.sv =====
package ypcb_pkg;

	// fixed-point formats
	localparam int ANG_FRAC   = 7;   // port angles: 1/2^ANG_FRAC degree
	localparam int VEC_FRAC   = 14;  // port vectors: Q2.VEC_FRAC
	localparam int ZF         = 20;  // rotator angle fraction bits (degrees)
	localparam int XF         = 30;  // rotator x/y fraction bits

	// field and datapath widths
	localparam int REQ_W      = 3;
	localparam int VALUE_W    = 17;
	localparam int PITCH_W    = 15;
	localparam int YAW_W      = 16;
	localparam int VEC_W      = 16;
	localparam int ACC_W      = 18;  // angle sum before clamp or wrap
	localparam int XY_W       = 32;
	localparam int Z_W        = 30;
	localparam int PROD_W     = 64;
	localparam int SHIFT_W    = 6;
	localparam int ATAN_N     = 24;
	localparam int ATAN_IDX_W = 5;

	// angle limits in port units
	localparam int PITCH_LIM  = 89 << ANG_FRAC;
	localparam int HALF_TURN  = 180 << ANG_FRAC;
	localparam int FULL_TURN  = 360 << ANG_FRAC;

	// rotator constants
	localparam int CORDIC_GAIN = 652032874;
	localparam int QUARTER_Z   = 90 << ZF;
	localparam int HALF_Z      = 180 << ZF;

	// rounding shifts and unit vector
	localparam int PROD_SHIFT = 2 * XF - VEC_FRAC;
	localparam int TRIG_SHIFT = XF - VEC_FRAC;
	localparam int VEC_ONE    = 1 << VEC_FRAC;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SET_BOTH  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET_PITCH = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SET_YAW   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ADD_BOTH  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_ADD_PITCH = 3'd4;
	localparam logic [REQ_W-1:0] REQ_ADD_YAW   = 3'd5;
	localparam logic [REQ_W-1:0] REQ_ZERO      = 3'd6;

	typedef struct packed {
		logic signed [XY_W-1:0] s;
		logic signed [XY_W-1:0] c;
	} trig_t;

	// basis components that need a product of two trig values
	typedef struct packed {
		logic signed [VEC_W-1:0] front_x;
		logic signed [VEC_W-1:0] front_y;
		logic signed [VEC_W-1:0] up_x;
		logic signed [VEC_W-1:0] up_y;
	} prod_vec_t;

	// arctangent of 2^-i in degrees, 20 fraction bits
	function automatic logic signed [Z_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [Z_W-1:0] a;
		case (idx)
			5'd0:    a = Z_W'(47185920);
			5'd1:    a = Z_W'(27855475);
			5'd2:    a = Z_W'(14718068);
			5'd3:    a = Z_W'(7471121);
			5'd4:    a = Z_W'(3750058);
			5'd5:    a = Z_W'(1876857);
			5'd6:    a = Z_W'(938658);
			5'd7:    a = Z_W'(469357);
			5'd8:    a = Z_W'(234682);
			5'd9:    a = Z_W'(117342);
			5'd10:   a = Z_W'(58671);
			5'd11:   a = Z_W'(29335);
			5'd12:   a = Z_W'(14668);
			5'd13:   a = Z_W'(7334);
			5'd14:   a = Z_W'(3667);
			5'd15:   a = Z_W'(1833);
			5'd16:   a = Z_W'(917);
			5'd17:   a = Z_W'(458);
			5'd18:   a = Z_W'(229);
			5'd19:   a = Z_W'(115);
			5'd20:   a = Z_W'(57);
			5'd21:   a = Z_W'(29);
			5'd22:   a = Z_W'(14);
			5'd23:   a = Z_W'(7);
			default: a = '0;
		endcase
		return a;
	endfunction

	// round to nearest (ties away from zero), saturate to +-1.0
	function automatic logic signed [VEC_W-1:0] round_vec(input logic signed [PROD_W-1:0] v,
			input logic [SHIFT_W-1:0] sh);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		logic [VEC_W-1:0]  m;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r = (mag + (PROD_W'(1) << (sh - SHIFT_W'(1)))) >> sh;
		if (r > PROD_W'(VEC_ONE)) begin
			r = PROD_W'(VEC_ONE);
		end
		m = VEC_W'(r);
		return v[PROD_W-1] ? -m : m;
	endfunction

endpackage

// ===== rtl/ypcb_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle.
// Angle folded into +-90 degrees first; result negated when folded.
module ypcb_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ypcb_pkg::YAW_W-1:0]   angle,
	output logic                                done,
	output ypcb_pkg::trig_t                     res
);

	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	localparam logic signed [ypcb_pkg::Z_W-1:0] QUARTER =
		ypcb_pkg::Z_W'(ypcb_pkg::QUARTER_Z);
	localparam logic signed [ypcb_pkg::Z_W-1:0] HALF =
		ypcb_pkg::Z_W'(ypcb_pkg::HALF_Z);

	logic                                busy_q;
	logic                                done_q;
	logic [STEP_W-1:0]                   step_q;
	logic signed [ypcb_pkg::XY_W-1:0]    x_q;
	logic signed [ypcb_pkg::XY_W-1:0]    y_q;
	logic signed [ypcb_pkg::Z_W-1:0]     z_q;
	logic                                neg_q;

	logic signed [ypcb_pkg::Z_W-1:0]     z_in;
	logic signed [ypcb_pkg::Z_W-1:0]     z_fold;
	logic                                fold;
	logic signed [ypcb_pkg::XY_W-1:0]    x_sh;
	logic signed [ypcb_pkg::XY_W-1:0]    y_sh;
	logic signed [ypcb_pkg::Z_W-1:0]     atan_i;

	// scale to rotator format and fold into the right half plane
	always_comb begin
		z_in = ypcb_pkg::Z_W'(angle) <<< (ypcb_pkg::ZF - ypcb_pkg::ANG_FRAC);
		fold = 1'b0;
		z_fold = z_in;
		if (z_in > QUARTER) begin
			z_fold = z_in - HALF;
			fold = 1'b1;
		end else if (z_in < -QUARTER) begin
			z_fold = z_in + HALF;
			fold = 1'b1;
		end
	end

	assign x_sh   = x_q >>> step_q;
	assign y_sh   = y_q >>> step_q;
	assign atan_i = ypcb_pkg::atan_deg(ypcb_pkg::ATAN_IDX_W'(step_q));

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shared micro-rotation datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= ypcb_pkg::XY_W'(ypcb_pkg::CORDIC_GAIN);
			y_q   <= '0;
			z_q   <= z_fold;
			neg_q <= fold;
		end else if (busy_q) begin
			if (!z_q[ypcb_pkg::Z_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_i;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_i;
			end
		end
	end

	assign done  = done_q;
	assign res.s = neg_q ? -y_q : y_q;
	assign res.c = neg_q ? -x_q : x_q;

endmodule

// ===== rtl/ypcb_vec.sv =====
// Shared multiplier for the four two-term basis components.
// One product per cycle, registered, then rounded into its slot.
module ypcb_vec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ypcb_pkg::trig_t       pitch_trig,
	input  ypcb_pkg::trig_t       yaw_trig,
	output logic                  done,
	output ypcb_pkg::prod_vec_t   prods
);

	localparam logic [1:0] IDX_FX = 2'd0;
	localparam logic [1:0] IDX_FY = 2'd1;
	localparam logic [1:0] IDX_UX = 2'd2;
	localparam logic [1:0] IDX_UY = 2'd3;

	logic                                busy_q;
	logic [1:0]                          idx_q;
	logic                                prod_vld_s1;
	logic [1:0]                          prod_idx_s1;
	logic signed [ypcb_pkg::PROD_W-1:0]  prod_s1;
	logic signed [ypcb_pkg::XY_W-1:0]    mul_a;
	logic signed [ypcb_pkg::XY_W-1:0]    mul_b;
	logic signed [ypcb_pkg::PROD_W-1:0]  prod;
	logic signed [ypcb_pkg::VEC_W-1:0]   rnd;
	ypcb_pkg::prod_vec_t                 prods_q;

	// operand pairs: cy*cp, sy*cp, cy*sp, sy*sp
	always_comb begin
		case (idx_q)
			IDX_FX: begin
				mul_a = yaw_trig.c;
				mul_b = pitch_trig.c;
			end
			IDX_FY: begin
				mul_a = yaw_trig.s;
				mul_b = pitch_trig.c;
			end
			IDX_UX: begin
				mul_a = yaw_trig.c;
				mul_b = pitch_trig.s;
			end
			IDX_UY: begin
				mul_a = yaw_trig.s;
				mul_b = pitch_trig.s;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign rnd  = ypcb_pkg::round_vec(prod_s1, ypcb_pkg::SHIFT_W'(ypcb_pkg::PROD_SHIFT));

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			prod_vld_s1 <= 1'b0;
			prod_idx_s1 <= '0;
		end else begin
			prod_vld_s1 <= busy_q;
			prod_idx_s1 <= idx_q;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == IDX_UY) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// product register and rounded results
	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (prod_vld_s1) begin
			case (prod_idx_s1)
				IDX_FX:  prods_q.front_x <= rnd;
				IDX_FY:  prods_q.front_y <= rnd;
				IDX_UX:  prods_q.up_x    <= -rnd;
				IDX_UY:  prods_q.up_y    <= -rnd;
				default: prods_q.front_x <= rnd;
			endcase
		end
	end

	assign done  = prod_vld_s1 && (prod_idx_s1 == IDX_UY);
	assign prods = prods_q;

endmodule

// ===== rtl/yaw_pitch_camera_basis_core.sv =====
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | req_type, pitch_value, yaw_value
// out     | out_valid / out_ready | pitch_now, yaw_now, front_*, right_*, up_*
//
// An item's time from transfer to result is set by the shared CORDIC rotator,
// run once for pitch and once for yaw, and grows with each turn taken off the
// yaw sum, at most two.
// in_ready is high only while idle. A result sits in the output register until
// transferred; the next item is taken meanwhile and stalls only at its end.
// Reset zeroes both angles and empties the output register.
module yaw_pitch_camera_basis_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [ypcb_pkg::REQ_W-1:0]              req_type,
	input  logic signed [ypcb_pkg::VALUE_W-1:0]     pitch_value,
	input  logic signed [ypcb_pkg::VALUE_W-1:0]     yaw_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [ypcb_pkg::PITCH_W-1:0]     pitch_now,
	output logic signed [ypcb_pkg::YAW_W-1:0]       yaw_now,
	output logic signed [ypcb_pkg::VEC_W-1:0]       front_x,
	output logic signed [ypcb_pkg::VEC_W-1:0]       front_y,
	output logic signed [ypcb_pkg::VEC_W-1:0]       front_z,
	output logic signed [ypcb_pkg::VEC_W-1:0]       right_x,
	output logic signed [ypcb_pkg::VEC_W-1:0]       right_y,
	output logic signed [ypcb_pkg::VEC_W-1:0]       right_z,
	output logic signed [ypcb_pkg::VEC_W-1:0]       up_x,
	output logic signed [ypcb_pkg::VEC_W-1:0]       up_y,
	output logic signed [ypcb_pkg::VEC_W-1:0]       up_z
);

	localparam int AW = ypcb_pkg::ACC_W;
	localparam logic signed [AW-1:0] P_MAX = AW'(ypcb_pkg::PITCH_LIM);
	localparam logic signed [AW-1:0] Y_HALF = AW'(ypcb_pkg::HALF_TURN);
	localparam logic signed [AW-1:0] Y_FULL = AW'(ypcb_pkg::FULL_TURN);
	localparam logic [ypcb_pkg::SHIFT_W-1:0] TSH =
		ypcb_pkg::SHIFT_W'(ypcb_pkg::TRIG_SHIFT);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRAP,
		S_PITCH,
		S_YAW,
		S_VEC,
		S_OUT
	} state_t;

	state_t                                   state_q;
	logic signed [ypcb_pkg::PITCH_W-1:0]      pitch_q;
	logic signed [ypcb_pkg::YAW_W-1:0]        yaw_q;
	logic signed [AW-1:0]                     yaw_acc_q;
	ypcb_pkg::trig_t                          pitch_trig_q;

	logic                                     out_valid_q;
	logic signed [ypcb_pkg::PITCH_W-1:0]      pitch_now_q;
	logic signed [ypcb_pkg::YAW_W-1:0]        yaw_now_q;
	logic signed [ypcb_pkg::VEC_W-1:0]        front_x_q;
	logic signed [ypcb_pkg::VEC_W-1:0]        front_y_q;
	logic signed [ypcb_pkg::VEC_W-1:0]        front_z_q;
	logic signed [ypcb_pkg::VEC_W-1:0]        right_x_q;
	logic signed [ypcb_pkg::VEC_W-1:0]        right_y_q;
	logic signed [ypcb_pkg::VEC_W-1:0]        up_x_q;
	logic signed [ypcb_pkg::VEC_W-1:0]        up_y_q;
	logic signed [ypcb_pkg::VEC_W-1:0]        up_z_q;

	logic                                     in_xfer;
	logic                                     yaw_in_range;
	logic                                     out_load;
	logic                                     pitch_upd;
	logic                                     pitch_add;
	logic                                     pitch_zero;
	logic signed [AW-1:0]                     pitch_sum;
	logic signed [AW-1:0]                     pitch_clamp;
	logic signed [AW-1:0]                     yaw_acc_d;

	logic                                     cordic_start;
	logic signed [ypcb_pkg::YAW_W-1:0]        cordic_angle;
	logic                                     cordic_done;
	ypcb_pkg::trig_t                          cordic_res;
	logic                                     vec_start;
	logic                                     vec_done;
	ypcb_pkg::prod_vec_t                      vec_prods;

	assign in_ready     = (state_q == S_IDLE);
	assign in_xfer      = in_valid && in_ready;
	assign yaw_in_range = (yaw_acc_q >= -Y_HALF) && (yaw_acc_q < Y_HALF);
	assign out_load     = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// request decode: which angle changes and how
	always_comb begin
		pitch_upd  = 1'b0;
		pitch_add  = 1'b0;
		pitch_zero = 1'b0;
		yaw_acc_d  = AW'(yaw_q);
		case (req_type)
			ypcb_pkg::REQ_SET_BOTH: begin
				pitch_upd = 1'b1;
				yaw_acc_d = AW'(yaw_value);
			end
			ypcb_pkg::REQ_SET_PITCH: pitch_upd = 1'b1;
			ypcb_pkg::REQ_SET_YAW:   yaw_acc_d = AW'(yaw_value);
			ypcb_pkg::REQ_ADD_BOTH: begin
				pitch_upd = 1'b1;
				pitch_add = 1'b1;
				yaw_acc_d = AW'(yaw_q) + AW'(yaw_value);
			end
			ypcb_pkg::REQ_ADD_PITCH: begin
				pitch_upd = 1'b1;
				pitch_add = 1'b1;
			end
			ypcb_pkg::REQ_ADD_YAW:   yaw_acc_d = AW'(yaw_q) + AW'(yaw_value);
			ypcb_pkg::REQ_ZERO: begin
				pitch_zero = 1'b1;
				yaw_acc_d  = '0;
			end
			default: ;
		endcase
	end

	// pitch update and saturation
	always_comb begin
		pitch_sum = (pitch_add ? AW'(pitch_q) : '0) + AW'(pitch_value);
		pitch_clamp = pitch_sum;
		if (pitch_sum > P_MAX) begin
			pitch_clamp = P_MAX;
		end else if (pitch_sum < -P_MAX) begin
			pitch_clamp = -P_MAX;
		end
	end

	// angle state; yaw commits once its sum is wrapped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			yaw_q   <= '0;
		end else begin
			if (in_xfer) begin
				if (pitch_zero) begin
					pitch_q <= '0;
				end else if (pitch_upd) begin
					pitch_q <= ypcb_pkg::PITCH_W'(pitch_clamp);
				end
			end
			if (state_q == S_WRAP && yaw_in_range) begin
				yaw_q <= ypcb_pkg::YAW_W'(yaw_acc_q);
			end
		end
	end

	// yaw wrap, one turn per cycle; pitch trig capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			yaw_acc_q <= yaw_acc_d;
		end else if (state_q == S_WRAP) begin
			if (yaw_acc_q >= Y_HALF) begin
				yaw_acc_q <= yaw_acc_q - Y_FULL;
			end else if (yaw_acc_q < -Y_HALF) begin
				yaw_acc_q <= yaw_acc_q + Y_FULL;
			end
		end
		if (state_q == S_PITCH && cordic_done) begin
			pitch_trig_q <= cordic_res;
		end
	end

	// rotator: pitch first, yaw right after
	assign cordic_start = (state_q == S_WRAP && yaw_in_range) ||
		(state_q == S_PITCH && cordic_done);
	assign cordic_angle = (state_q == S_WRAP) ? ypcb_pkg::YAW_W'(pitch_q) : yaw_q;
	assign vec_start    = (state_q == S_YAW) && cordic_done;

	ypcb_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (cordic_angle),
		.done   (cordic_done),
		.res    (cordic_res)
	);

	ypcb_vec u_vec (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (vec_start),
		.pitch_trig (pitch_trig_q),
		.yaw_trig   (cordic_res),
		.done       (vec_done),
		.prods      (vec_prods)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			pitch_now_q <= '0;
			yaw_now_q   <= '0;
			front_x_q   <= '0;
			front_y_q   <= '0;
			front_z_q   <= '0;
			right_x_q   <= '0;
			right_y_q   <= '0;
			up_x_q      <= '0;
			up_y_q      <= '0;
			up_z_q      <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (yaw_in_range) begin
						state_q <= S_PITCH;
					end
				end
				S_PITCH: begin
					if (cordic_done) begin
						state_q <= S_YAW;
					end
				end
				S_YAW: begin
					if (cordic_done) begin
						state_q <= S_VEC;
					end
				end
				S_VEC: begin
					if (vec_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						pitch_now_q <= pitch_q;
						yaw_now_q   <= yaw_q;
						front_x_q   <= vec_prods.front_x;
						front_y_q   <= vec_prods.front_y;
						front_z_q   <= ypcb_pkg::round_vec(ypcb_pkg::PROD_W'(pitch_trig_q.s), TSH);
						right_x_q   <= ypcb_pkg::round_vec(ypcb_pkg::PROD_W'(cordic_res.s), TSH);
						right_y_q   <= -ypcb_pkg::round_vec(ypcb_pkg::PROD_W'(cordic_res.c), TSH);
						up_x_q      <= vec_prods.up_x;
						up_y_q      <= vec_prods.up_y;
						up_z_q      <= ypcb_pkg::round_vec(ypcb_pkg::PROD_W'(pitch_trig_q.c), TSH);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pitch_now = pitch_now_q;
	assign yaw_now   = yaw_now_q;
	assign front_x   = front_x_q;
	assign front_y   = front_y_q;
	assign front_z   = front_z_q;
	assign right_x   = right_x_q;
	assign right_y   = right_y_q;
	assign right_z   = '0;
	assign up_x      = up_x_q;
	assign up_y      = up_y_q;
	assign up_z      = up_z_q;

endmodule

// ===== rtl/ypcb_checker.sv =====
// Port-level checks for the camera basis core.
module ypcb_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic signed [ypcb_pkg::PITCH_W-1:0]     pitch_now,
	input  logic signed [ypcb_pkg::YAW_W-1:0]       yaw_now,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       front_x,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       front_y,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       front_z,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       right_x,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       right_y,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       right_z,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       up_x,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       up_y,
	input  logic signed [ypcb_pkg::VEC_W-1:0]       up_z
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pitch_now) && $stable(yaw_now)
			&& $stable(front_x) && $stable(front_y) && $stable(front_z)
			&& $stable(right_x) && $stable(right_y) && $stable(up_x)
			&& $stable(up_y) && $stable(up_z))
		else $error("result changed while stalled");

	// the block is not ready again right after a transfer in
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// pitch saturates to the limit
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_now <= ypcb_pkg::PITCH_LIM) && (pitch_now >= -ypcb_pkg::PITCH_LIM))
		else $error("pitch outside its limit");

	// yaw wrapped into one turn
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw_now < ypcb_pkg::HALF_TURN) && (yaw_now >= -ypcb_pkg::HALF_TURN))
		else $error("yaw not wrapped");

	// right vector stays in the horizontal plane
	a_right_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> right_z == '0)
		else $error("right vector has a vertical component");

endmodule

bind yaw_pitch_camera_basis_core ypcb_checker u_ypcb_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

typedef logic signed [ypcb_pkg::PITCH_W-1:0] pitch_t;
typedef logic signed [ypcb_pkg::YAW_W-1:0]   yaw_t;
typedef logic signed [ypcb_pkg::VEC_W-1:0]   vec_t;
typedef logic signed [ypcb_pkg::VALUE_W-1:0] value_t;
typedef logic [ypcb_pkg::REQ_W-1:0]          req_t;

// one camera basis as it leaves the block
typedef struct packed {
	pitch_t pitch_now;
	yaw_t   yaw_now;
	vec_t   front_x;
	vec_t   front_y;
	vec_t   front_z;
	vec_t   right_x;
	vec_t   right_y;
	vec_t   right_z;
	vec_t   up_x;
	vec_t   up_y;
	vec_t   up_z;
} basis_t;

// tracks pitch/yaw, predicts the basis for each transfer, checks results in order
class basis_scoreboard;
	localparam int     STEPS      = 16;
	localparam int     PORT_FRAC  = 7;
	localparam int     ROT_FRAC   = 20;
	localparam int     SC_FRAC    = 30;
	localparam int     OUT_FRAC   = 14;
	localparam longint START_X    = 652032874;
	localparam longint PITCH_MAX  = 89 << PORT_FRAC;
	localparam longint YAW_HALF   = 180 << PORT_FRAC;
	localparam longint YAW_FULL   = 360 << PORT_FRAC;
	localparam longint ROT_90     = 64'sd90 << ROT_FRAC;
	localparam longint ROT_180    = 64'sd180 << ROT_FRAC;
	localparam int     PROD_SH    = 2 * SC_FRAC - OUT_FRAC;
	localparam int     TRIG_SH    = SC_FRAC - OUT_FRAC;

	longint arctan[24];
	longint pitch_q;
	longint yaw_q;
	basis_t basis_q[$];
	int     failures;

	function new();
		arctan = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
			469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
			229, 115, 57, 29, 14, 7};
		pitch_q = 0;
		yaw_q = 0;
		failures = 0;
	endfunction

	function int pending();
		return basis_q.size();
	endfunction

	function longint clamp_pitch(longint v);
		if (v > PITCH_MAX) return PITCH_MAX;
		if (v < -PITCH_MAX) return -PITCH_MAX;
		return v;
	endfunction

	function longint wrap_yaw(longint v);
		longint m;
		m = (v + YAW_HALF) % YAW_FULL;
		if (m < 0) m += YAW_FULL;
		return m - YAW_HALF;
	endfunction

	// rotation-mode CORDIC, folded into +-90 degrees first
	function void sin_cos(longint ang, output longint s, output longint c);
		longint z, x, y, nx;
		bit     flip;
		int     i;
		z = ang <<< (ROT_FRAC - PORT_FRAC);
		x = START_X;
		y = 0;
		flip = 1'b0;
		if (z > ROT_90) begin
			z -= ROT_180;
			flip = 1'b1;
		end else if (z < -ROT_90) begin
			z += ROT_180;
			flip = 1'b1;
		end
		for (i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	// nearest, ties away from zero, saturated to +-1.0
	function vec_t to_q14(longint v, int sh);
		longint mag, r;
		mag = (v < 0) ? -v : v;
		r = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
		if (r > (64'sd1 <<< OUT_FRAC)) r = 64'sd1 <<< OUT_FRAC;
		return vec_t'((v < 0) ? -r : r);
	endfunction

	function void note_request(req_t code, value_t pv, value_t yv);
		longint p, y, sp, cp, sy, cy;
		basis_t e;
		p = pv;
		y = yv;
		case (code)
			ypcb_pkg::REQ_SET_BOTH: begin
				pitch_q = clamp_pitch(p);
				yaw_q = wrap_yaw(y);
			end
			ypcb_pkg::REQ_SET_PITCH: pitch_q = clamp_pitch(p);
			ypcb_pkg::REQ_SET_YAW:   yaw_q = wrap_yaw(y);
			ypcb_pkg::REQ_ADD_BOTH: begin
				pitch_q = clamp_pitch(pitch_q + p);
				yaw_q = wrap_yaw(yaw_q + y);
			end
			ypcb_pkg::REQ_ADD_PITCH: pitch_q = clamp_pitch(pitch_q + p);
			ypcb_pkg::REQ_ADD_YAW:   yaw_q = wrap_yaw(yaw_q + y);
			ypcb_pkg::REQ_ZERO: begin
				pitch_q = 0;
				yaw_q = 0;
			end
			default: ;
		endcase
		sin_cos(pitch_q, sp, cp);
		sin_cos(yaw_q, sy, cy);
		e.pitch_now = pitch_t'(pitch_q);
		e.yaw_now   = yaw_t'(yaw_q);
		e.front_x   = to_q14(cy * cp, PROD_SH);
		e.front_y   = to_q14(sy * cp, PROD_SH);
		e.front_z   = to_q14(sp, TRIG_SH);
		e.right_x   = to_q14(sy, TRIG_SH);
		e.right_y   = to_q14(-cy, TRIG_SH);
		e.right_z   = '0;
		e.up_x      = to_q14(-(cy * sp), PROD_SH);
		e.up_y      = to_q14(-(sy * sp), PROD_SH);
		e.up_z      = to_q14(cp, TRIG_SH);
		basis_q.push_back(e);
	endfunction

	function void compare_field(string name, longint want, longint got);
		if (want != got) begin
			failures++;
			if (failures <= 10)
				$display("mismatch %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	function void check_result(basis_t got);
		basis_t want;
		if (basis_q.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("result with nothing pending: pitch_now %0d yaw_now %0d",
					got.pitch_now, got.yaw_now);
			return;
		end
		want = basis_q.pop_front();
		compare_field("pitch_now", want.pitch_now, got.pitch_now);
		compare_field("yaw_now", want.yaw_now, got.yaw_now);
		compare_field("front_x", want.front_x, got.front_x);
		compare_field("front_y", want.front_y, got.front_y);
		compare_field("front_z", want.front_z, got.front_z);
		compare_field("right_x", want.right_x, got.right_x);
		compare_field("right_y", want.right_y, got.right_y);
		compare_field("right_z", want.right_z, got.right_z);
		compare_field("up_x", want.up_x, got.up_x);
		compare_field("up_y", want.up_y, got.up_y);
		compare_field("up_z", want.up_z, got.up_z);
	endfunction
endclass

module testbench;

	localparam req_t REQ_UNUSED   = 3'd7;
	localparam int   RAND_ITEMS   = 550;
	localparam int   CALM_ITEMS   = 60;
	localparam int   DRAIN_CYCLES = 50;
	localparam int   CYCLE_LIMIT  = 400000;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	req_t   req_type = '0;
	value_t pitch_value = '0;
	value_t yaw_value = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	pitch_t pitch_now;
	yaw_t   yaw_now;
	vec_t   front_x, front_y, front_z;
	vec_t   right_x, right_y, right_z;
	vec_t   up_x, up_y, up_z;

	basis_scoreboard sb = new();
	bit calm = 1'b0;
	int cycles = 0;

	yaw_pitch_camera_basis_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.pitch_value (pitch_value),
		.yaw_value   (yaw_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pitch_now   (pitch_now),
		.yaw_now     (yaw_now),
		.front_x     (front_x),
		.front_y     (front_y),
		.front_z     (front_z),
		.right_x     (right_x),
		.right_y     (right_y),
		.right_z     (right_z),
		.up_x        (up_x),
		.up_y        (up_y),
		.up_z        (up_z)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// result side: check every transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{pitch_now, yaw_now, front_x, front_y, front_z,
				right_x, right_y, right_z, up_x, up_y, up_z});
	end

	// result side backpressure: stall bursts between open stretches
	initial begin
		wait (arst_n);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// one request transfer, optionally preceded by an idle burst
	task automatic send_request(req_t code, value_t pv, value_t yv);
		if (!calm && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= code;
		pitch_value <= pv;
		yaw_value   <= yv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(code, pv, yv);
	endtask

	// angle operand: in range, small step, near a limit or right angle, or any bits
	function automatic value_t pick_angle(bit for_pitch);
		int sel, v;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			v = int'($urandom_range(0, 92159)) - 46080;
		end else if (sel < 62) begin
			v = int'($urandom_range(0, 1024)) - 512;
		end else if (sel < 80) begin
			if (for_pitch)
				v = ($urandom_range(0, 1) ? 11392 : -11392) + int'($urandom_range(0, 8)) - 4;
			else
				v = 11520 * (int'($urandom_range(0, 8)) - 4) + int'($urandom_range(0, 4)) - 2;
		end else begin
			v = int'($urandom());
		end
		return value_t'(v);
	endfunction

	// stimulus
	initial begin
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: limits, wraps, every code, ignored operands
		send_request(ypcb_pkg::REQ_SET_BOTH, 17'sd0, 17'sd0);
		send_request(ypcb_pkg::REQ_SET_PITCH, 17'sd11392, -17'sd30000);
		send_request(ypcb_pkg::REQ_SET_PITCH, 17'sd11393, 17'sd65535);
		send_request(ypcb_pkg::REQ_SET_PITCH, -17'sd11393, 17'sd0);
		send_request(ypcb_pkg::REQ_SET_PITCH, 17'sd65535, 17'sd0);
		send_request(ypcb_pkg::REQ_SET_PITCH, -17'sd65536, 17'sd0);
		send_request(ypcb_pkg::REQ_SET_YAW, 17'sd46079, 17'sd23039);
		send_request(ypcb_pkg::REQ_SET_YAW, -17'sd65536, -17'sd23040);
		send_request(ypcb_pkg::REQ_SET_YAW, 17'sd0, 17'sd23040);
		send_request(ypcb_pkg::REQ_SET_YAW, 17'sd0, 17'sd11520);
		send_request(ypcb_pkg::REQ_SET_YAW, 17'sd0, -17'sd11520);
		send_request(ypcb_pkg::REQ_SET_BOTH, 17'sd46079, -17'sd46080);
		send_request(ypcb_pkg::REQ_SET_BOTH, -17'sd46080, 17'sd65535);
		send_request(ypcb_pkg::REQ_ADD_PITCH, -17'sd65536, 17'sd1234);
		send_request(ypcb_pkg::REQ_ADD_PITCH, 17'sd46079, 17'sd0);
		send_request(ypcb_pkg::REQ_SET_YAW, 17'sd0, 17'sd23039);
		send_request(ypcb_pkg::REQ_ADD_YAW, 17'sd40000, 17'sd65535);
		send_request(ypcb_pkg::REQ_ADD_YAW, 17'sd0, -17'sd65536);
		send_request(ypcb_pkg::REQ_ADD_BOTH, 17'sd1, 17'sd1);
		send_request(ypcb_pkg::REQ_ADD_BOTH, -17'sd46080, 17'sd46079);
		send_request(REQ_UNUSED, 17'sd5000, -17'sd5000);
		send_request(ypcb_pkg::REQ_ZERO, -17'sd1, -17'sd1);
		send_request(REQ_UNUSED, 17'sd0, 17'sd0);

		// random requests, the tail without idling
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
			send_request(req_t'($urandom_range(0, 7)), pick_angle(1'b1), pick_angle(1'b0));
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ypcb_pkg.sv
rtl/ypcb_cordic.sv
rtl/ypcb_vec.sv
rtl/yaw_pitch_camera_basis_core.sv
rtl/ypcb_checker.sv
dv/testbench.sv
